### rtl/dsi_pkg.sv
// Package: shared types and constants of the drive safety interlock.
`timescale 1ns / 1ps

package dsi_pkg;

  // Configuration register reset values
  localparam logic [15:0] SensorMaxAgeRst = 16'd100;
  localparam logic [15:0] CmdTimeoutRst   = 16'd1000;
  localparam logic [14:0] StepPeriodRst   = 15'd50;
  localparam logic [13:0] MaxLevelRst     = 14'd10000;

  // Stream widths
  localparam int unsigned InDataW  = 120;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [1:0] {
    CFG_SENSOR_MAX_AGE = 2'd0,
    CFG_CMD_TIMEOUT    = 2'd1,
    CFG_STEP_PERIOD    = 2'd2,
    CFG_MAX_LEVEL      = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_STEP    = 1'b0,
    REQ_COMMAND = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    CMD_STOP    = 2'd0,
    CMD_RESET   = 2'd1,
    CMD_MANUAL  = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_MANUAL  = 2'd1,
    MODE_FAULT   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    FLT_NONE      = 3'd0,
    FLT_NOT_READY = 3'd1,
    FLT_INTERLOCK = 3'd2,
    FLT_SENSOR    = 3'd3,
    FLT_TIMEOUT   = 3'd4,
    FLT_TIMING    = 3'd5
  } fault_e;

  typedef struct packed {
    logic [15:0] sensor_max_age_ms;
    logic [15:0] command_timeout_ms;
    logic [14:0] step_period_ms;
    logic [13:0] max_level;
  } cfg_t;

  typedef struct packed {
    req_e               req_type;
    cmd_e               cmd_kind;
    logic signed [15:0] level_request;
    logic [31:0]        now_ms;
    logic               ready_req;
    logic               door_shut;
    logic               stop_chain_ok;
    logic               sample_valid;
    logic [31:0]        sample_time_ms;
    logic               values_finite;
    logic signed [15:0] air_before;
    logic signed [15:0] air_after;
  } req_t;

  typedef struct packed {
    logic        accepted;
    mode_e       run_state;
    fault_e      fault_code;
    logic [13:0] drive_level;
  } res_t;

endpackage

### rtl/dsi_cfg_regs.sv
// Module: configuration register file of the drive safety interlock.
`timescale 1ns / 1ps

module dsi_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  dsi_pkg::cfg_idx_e   cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output dsi_pkg::cfg_t       cfg_o
);
  import dsi_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Take a write in every cycle
  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SENSOR_MAX_AGE: cfg_d.sensor_max_age_ms  = cfg_data_i;
        CFG_CMD_TIMEOUT:    cfg_d.command_timeout_ms = cfg_data_i;
        CFG_STEP_PERIOD:    cfg_d.step_period_ms     = cfg_data_i[14:0];
        CFG_MAX_LEVEL:      cfg_d.max_level          = cfg_data_i[13:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_max_age_ms  <= SensorMaxAgeRst;
      cfg_q.command_timeout_ms <= CmdTimeoutRst;
      cfg_q.step_period_ms     <= StepPeriodRst;
      cfg_q.max_level          <= MaxLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/dsi_health.sv
// Module: sensor snapshot checks, giving the highest priority health fault.
`timescale 1ns / 1ps

module dsi_health (
  input  dsi_pkg::req_t   req_i,
  input  logic [15:0]     sensor_max_age_i,
  output dsi_pkg::fault_e why_o
);
  import dsi_pkg::*;

  logic [31:0] age;
  logic        stale;
  logic        sensor_bad;

  // Age wraps, so a sample from the future looks old
  assign age   = req_i.now_ms - req_i.sample_time_ms;
  assign stale = age > {16'd0, sensor_max_age_i};

  assign sensor_bad = !req_i.sample_valid || stale || !req_i.values_finite ||
                      req_i.air_before[15] || req_i.air_after[15];

  // Report in priority order
  always_comb begin
    if (!req_i.ready_req) begin
      why_o = FLT_NOT_READY;
    end else if (!req_i.door_shut || !req_i.stop_chain_ok) begin
      why_o = FLT_INTERLOCK;
    end else if (sensor_bad) begin
      why_o = FLT_SENSOR;
    end else begin
      why_o = FLT_NONE;
    end
  end

endmodule

### rtl/dsi_ctrl.sv
// Module: interlock state and per-item decision logic.
`timescale 1ns / 1ps

module dsi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  dsi_pkg::req_t req_i,
  input  dsi_pkg::cfg_t cfg_i,
  output dsi_pkg::res_t res_o
);
  import dsi_pkg::*;

  mode_e       mode_q,  mode_d;
  fault_e      fault_q, fault_d;
  logic [13:0] level_q, level_d;
  logic [31:0] last_cmd_q, last_cmd_d;
  logic [31:0] last_step_q, last_step_d;
  logic        stepped_q, stepped_d;
  logic        accepted;

  fault_e      why;
  logic [31:0] cmd_gap;
  logic [31:0] step_gap;
  logic        timed_out;
  logic        late_step;
  logic        level_bad;

  dsi_health u_health (
    .req_i            (req_i),
    .sensor_max_age_i (cfg_i.sensor_max_age_ms),
    .why_o            (why)
  );

  assign cmd_gap   = req_i.now_ms - last_cmd_q;
  assign step_gap  = req_i.now_ms - last_step_q;
  assign timed_out = cmd_gap >= {16'd0, cfg_i.command_timeout_ms};
  assign late_step = stepped_q && (step_gap > {16'd0, cfg_i.step_period_ms, 1'b0});
  assign level_bad = req_i.level_request[15] ||
                     (req_i.level_request[14:0] > {1'b0, cfg_i.max_level});

  // Work out the next state for this item
  always_comb begin
    mode_d      = mode_q;
    fault_d     = fault_q;
    level_d     = level_q;
    last_cmd_d  = last_cmd_q;
    last_step_d = last_step_q;
    stepped_d   = stepped_q;
    accepted    = 1'b1;

    if (req_i.req_type == REQ_STEP) begin
      // Trip on health, command timeout or lost step timing
      if (mode_q == MODE_MANUAL) begin
        if (why != FLT_NONE) begin
          mode_d  = MODE_FAULT;
          fault_d = why;
        end else if (timed_out) begin
          mode_d  = MODE_FAULT;
          fault_d = FLT_TIMEOUT;
        end else if (late_step) begin
          mode_d  = MODE_FAULT;
          fault_d = FLT_TIMING;
        end
      end
      if (mode_d != MODE_MANUAL) begin
        level_d = '0;
      end
      last_step_d = req_i.now_ms;
      stepped_d   = 1'b1;
    end else begin
      case (req_i.cmd_kind)
        CMD_STOP: begin
          level_d = '0;
          if (mode_q != MODE_FAULT) mode_d = MODE_STOPPED;
        end
        CMD_RESET: begin
          if (mode_q == MODE_MANUAL || why != FLT_NONE) begin
            accepted = 1'b0;
          end else begin
            mode_d      = MODE_STOPPED;
            fault_d     = FLT_NONE;
            level_d     = '0;
            last_cmd_d  = '0;
            last_step_d = req_i.now_ms;
            stepped_d   = 1'b1;
          end
        end
        CMD_MANUAL: begin
          if (level_bad) begin
            accepted = 1'b0;
          end else if (req_i.level_request == '0) begin
            // Zero level acts as stop
            level_d = '0;
            if (mode_q != MODE_FAULT) mode_d = MODE_STOPPED;
          end else if (mode_q == MODE_FAULT) begin
            accepted = 1'b0;
          end else if (why != FLT_NONE) begin
            mode_d   = MODE_FAULT;
            fault_d  = why;
            level_d  = '0;
            accepted = 1'b0;
          end else begin
            mode_d     = MODE_MANUAL;
            level_d    = req_i.level_request[13:0];
            last_cmd_d = req_i.now_ms;
          end
        end
        default: accepted = 1'b0;
      endcase
    end
  end

  // Hold state unless an item is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_STOPPED;
      fault_q     <= FLT_NONE;
      level_q     <= '0;
      last_cmd_q  <= '0;
      last_step_q <= '0;
      stepped_q   <= 1'b0;
    end else if (fire_i) begin
      mode_q      <= mode_d;
      fault_q     <= fault_d;
      level_q     <= level_d;
      last_cmd_q  <= last_cmd_d;
      last_step_q <= last_step_d;
      stepped_q   <= stepped_d;
    end
  end

  // Result reflects the state after this item
  assign res_o.accepted    = accepted;
  assign res_o.run_state   = mode_d;
  assign res_o.fault_code  = fault_d;
  assign res_o.drive_level = level_d;

endmodule

### rtl/drive_safety_interlock.sv
// Top level: drive safety interlock with input stage, decision logic and result register.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+---------------------------
//   s_axis   | in        | s_axis_tvalid/s_axis_tready | request, sensor snapshot
//   m_axis   | out       | m_axis_tvalid/m_axis_tready | status result
//   cfg      | in        | cfg_valid_i/cfg_ready_o     | register index, write data
//
// One item a cycle while results are taken: an item is held in the input register,
// is decided and lands in the result register, from which its result is offered
// on m_axis.
// Reset clears the mode, latched fault, level and timestamps, and restores the
// configuration defaults.
// A stalled result holds the result register; the input register still takes one
// more item, then ready falls until the result is taken.
`timescale 1ns / 1ps

module drive_safety_interlock (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // level_request[15:0], now_ms[47:16], ready_req[48], door_shut[49],
  // stop_chain_ok[50], sample_valid[51], sample_time_ms[83:52], values_finite[84],
  // air_before[100:85], air_after[116:101], zero fill[119:117]
  input  logic [119:0]         s_axis_tdata,
  // req_type[0], cmd_kind[2:1]
  input  logic [2:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // accepted[0], run_state[2:1], fault_code[5:3], drive_level[19:6], zero fill[23:20]
  output logic [23:0]          m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import dsi_pkg::*;

  cfg_t cfg;
  req_t in_req;
  req_t req_q;
  logic req_valid_q;
  logic advance;
  res_t res;
  res_t res_q;
  logic res_valid_q;

  dsi_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Unpack the input transfer
  assign in_req.req_type       = req_e'(s_axis_tuser[0]);
  assign in_req.cmd_kind       = cmd_e'(s_axis_tuser[2:1]);
  assign in_req.level_request  = s_axis_tdata[15:0];
  assign in_req.now_ms         = s_axis_tdata[47:16];
  assign in_req.ready_req      = s_axis_tdata[48];
  assign in_req.door_shut      = s_axis_tdata[49];
  assign in_req.stop_chain_ok  = s_axis_tdata[50];
  assign in_req.sample_valid   = s_axis_tdata[51];
  assign in_req.sample_time_ms = s_axis_tdata[83:52];
  assign in_req.values_finite  = s_axis_tdata[84];
  assign in_req.air_before     = s_axis_tdata[100:85];
  assign in_req.air_after      = s_axis_tdata[116:101];

  // Advance when the result register is free or being drained
  assign advance       = req_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !req_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= in_req;
    end
  end

  dsi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  // Pack the output transfer
  assign m_axis_tvalid        = res_valid_q;
  assign m_axis_tdata[0]      = res_q.accepted;
  assign m_axis_tdata[2:1]    = res_q.run_state;
  assign m_axis_tdata[5:3]    = res_q.fault_code;
  assign m_axis_tdata[19:6]   = res_q.drive_level;
  assign m_axis_tdata[23:20]  = 4'd0;

endmodule

### dv/drive_safety_interlock_tb.sv
// Testbench: drive safety interlock checked against a cycle-free model of its state machine.
`timescale 1ns / 1ps

module drive_safety_interlock_tb;
  import dsi_pkg::*;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned RandPerPhase = 125;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata  = '0;
  logic [2:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i   = '0;
  logic [15:0]  cfg_data_i    = '0;

  drive_safety_interlock uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be sent, and statuses owed by the block
  req_t        pending_req[$];
  res_t        status_due[$];
  req_t        on_bus;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int          mismatches     = 0;
  logic [31:0] clock_ms       = '0;

  // Shadow of the configuration and the controller state
  cfg_t        cfg_q = {SensorMaxAgeRst, CmdTimeoutRst, StepPeriodRst, MaxLevelRst};
  mode_e       mode_q    = MODE_STOPPED;
  fault_e      fault_q   = FLT_NONE;
  logic [13:0] level_q   = '0;
  logic [31:0] cmd_ms_q  = '0;
  logic [31:0] step_ms_q = '0;
  logic        stepped_q = 1'b0;

  // Sensor health in priority order: ready, interlocks, then sample quality
  function automatic fault_e sensor_check(req_t r);
    logic [31:0] age;
    age = r.now_ms - r.sample_time_ms;
    if (!r.ready_req) return FLT_NOT_READY;
    if (!r.door_shut || !r.stop_chain_ok) return FLT_INTERLOCK;
    if (!r.sample_valid || (age > 32'(cfg_q.sensor_max_age_ms)) || !r.values_finite ||
        r.air_before[15] || r.air_after[15]) return FLT_SENSOR;
    return FLT_NONE;
  endfunction

  function automatic void latch_fault(fault_e why);
    mode_q  = MODE_FAULT;
    fault_q = why;
    level_q = '0;
  endfunction

  // Stop drops the level but leaves a latched fault in place
  function automatic void halt_drive();
    level_q = '0;
    if (mode_q != MODE_FAULT) mode_q = MODE_STOPPED;
  endfunction

  function automatic res_t predict_status(req_t r);
    res_t        s;
    fault_e      why;
    logic [15:0] raw;
    s.accepted = 1'b1;
    raw = r.level_request;
    why = sensor_check(r);
    if (r.req_type == REQ_STEP) begin
      if (mode_q == MODE_MANUAL) begin
        if (why != FLT_NONE) begin
          latch_fault(why);
        end else if ((r.now_ms - cmd_ms_q) >= 32'(cfg_q.command_timeout_ms)) begin
          latch_fault(FLT_TIMEOUT);
        end else if (stepped_q &&
                     ((r.now_ms - step_ms_q) > (32'(cfg_q.step_period_ms) * 2))) begin
          latch_fault(FLT_TIMING);
        end
      end
      if (mode_q != MODE_MANUAL) level_q = '0;
      step_ms_q = r.now_ms;
      stepped_q = 1'b1;
    end else begin
      case (r.cmd_kind)
        CMD_STOP: halt_drive();
        CMD_RESET: begin
          if (mode_q == MODE_MANUAL || why != FLT_NONE) begin
            s.accepted = 1'b0;
          end else begin
            mode_q    = MODE_STOPPED;
            fault_q   = FLT_NONE;
            level_q   = '0;
            cmd_ms_q  = '0;
            step_ms_q = r.now_ms;
            stepped_q = 1'b1;
          end
        end
        CMD_MANUAL: begin
          if (raw[15] || raw > 16'(cfg_q.max_level)) begin
            s.accepted = 1'b0;
          end else if (raw == '0) begin
            halt_drive();
          end else if (mode_q == MODE_FAULT) begin
            s.accepted = 1'b0;
          end else if (why != FLT_NONE) begin
            latch_fault(why);
            s.accepted = 1'b0;
          end else begin
            mode_q   = MODE_MANUAL;
            level_q  = raw[13:0];
            cmd_ms_q = r.now_ms;
          end
        end
        default: s.accepted = 1'b0;
      endcase
    end
    s.run_state   = mode_q;
    s.fault_code  = fault_q;
    s.drive_level = level_q;
    return s;
  endfunction

  // Request with a fresh, fully healthy sensor snapshot
  function automatic req_t healthy_req(req_e kind, cmd_e cmd, logic [15:0] lvl,
                                       logic [31:0] t);
    req_t r;
    r                = '0;
    r.req_type       = kind;
    r.cmd_kind       = cmd;
    r.level_request  = lvl;
    r.now_ms         = t;
    r.ready_req      = 1'b1;
    r.door_shut      = 1'b1;
    r.stop_chain_ok  = 1'b1;
    r.sample_valid   = 1'b1;
    r.sample_time_ms = t;
    r.values_finite  = 1'b1;
    r.air_before     = 16'd1500;
    r.air_after      = 16'd1400;
    return r;
  endfunction

  // Mostly plausible traffic: time advancing near the step period, legal levels,
  // healthy sensors; now and then a broken snapshot, a timeout edge or a time jump
  function automatic req_t make_request();
    req_t        r;
    cmd_e        cmd;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      clock_ms += $urandom_range(0, 2 * cfg_q.step_period_ms + 1);
    end else if (pick < 97) begin
      clock_ms += cfg_q.command_timeout_ms + $urandom_range(0, 2) - 1;
    end else begin
      clock_ms = $urandom();
    end
    pick = $urandom_range(0, 99);
    cmd = (pick < 45) ? CMD_MANUAL : (pick < 70) ? CMD_RESET :
          (pick < 90) ? CMD_STOP : CMD_UNKNOWN;
    r = healthy_req(($urandom_range(0, 99) < 65) ? REQ_STEP : REQ_COMMAND, cmd, 16'd0,
                    clock_ms);
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      r.level_request = (cfg_q.max_level == '0) ? 16'd0 :
                        16'($urandom_range(1, cfg_q.max_level));
    end else if (pick < 88) begin
      r.level_request = '0;
    end else if (pick < 94) begin
      r.level_request = 16'(cfg_q.max_level) + 16'd1;
    end else begin
      r.level_request = 16'($urandom());
    end
    r.sample_time_ms = clock_ms - $urandom_range(0, cfg_q.sensor_max_age_ms);
    r.air_before = 16'($urandom_range(0, 32767));
    r.air_after  = 16'($urandom_range(0, 32767));
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 7))
        0: r.ready_req = 1'b0;
        1: r.door_shut = 1'b0;
        2: r.stop_chain_ok = 1'b0;
        3: r.sample_valid = 1'b0;
        4: r.sample_time_ms = clock_ms - cfg_q.sensor_max_age_ms - $urandom_range(1, 1000);
        5: r.sample_time_ms = $urandom();
        6: r.values_finite = 1'b0;
        default: begin
          r.air_before = 16'($urandom_range(32768, 65535));
          r.air_after  = 16'($urandom());
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_field(string name, logic [13:0] expv, logic [13:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SENSOR_MAX_AGE: cfg_q.sensor_max_age_ms = val;
      CFG_CMD_TIMEOUT:    cfg_q.command_timeout_ms = val;
      CFG_STEP_PERIOD:    cfg_q.step_period_ms = val[14:0];
      default:            cfg_q.max_level = val[13:0];
    endcase
  endtask

  // Wait until every request is sent and answered, then let the pipeline settle
  task automatic drain();
    while (pending_req.size() != 0 || s_axis_tvalid || status_due.size() != 0)
      @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned phase, logic [15:0] age, logic [15:0] tmo,
                           logic [15:0] period, logic [15:0] lvl);
    write_reg(CFG_SENSOR_MAX_AGE, age);
    write_reg(CFG_CMD_TIMEOUT, tmo);
    write_reg(CFG_STEP_PERIOD, period);
    write_reg(CFG_MAX_LEVEL, lvl);
    @(negedge clk_i);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
    clock_ms = $urandom();
    repeat (RandPerPhase) pending_req.push_back(make_request());
    drain();
  endtask

  // Request driver: present the next request once the current one is taken
  always @(posedge clk_i) begin
    req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) status_due.push_back(predict_status(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_req.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_req.pop_front();
          on_bus        <= nxt;
          s_axis_tdata  <= {3'b000, nxt.air_after, nxt.air_before, nxt.values_finite,
                            nxt.sample_time_ms, nxt.sample_valid, nxt.stop_chain_ok,
                            nxt.door_shut, nxt.ready_req, nxt.now_ms,
                            nxt.level_request};
          s_axis_tuser  <= {nxt.cmd_kind, nxt.req_type};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Status monitor: compare each transfer with the oldest owed status
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_due.size() == 0) begin
          $display("%0t: status with nothing owed, expected none, actual %h", $time,
                   m_axis_tdata);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          report_field("accepted", 14'(want.accepted), 14'(m_axis_tdata[0]));
          report_field("run_state", 14'(want.run_state), 14'(m_axis_tdata[2:1]));
          report_field("fault_code", 14'(want.fault_code), 14'(m_axis_tdata[5:3]));
          report_field("drive_level", want.drive_level, m_axis_tdata[19:6]);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: give up when no channel has moved for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_t r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed sequence on the reset configuration
    pending_req.push_back(healthy_req(REQ_STEP, CMD_STOP, 16'd0, 32'd10));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_STOP, 16'd0, 32'd12));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_MANUAL, 16'd0, 32'd14));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_MANUAL, 16'h8000, 32'd15));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_MANUAL, 16'h7FFF, 32'd15));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_MANUAL, 16'd10001, 32'd15));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_UNKNOWN, 16'd500, 32'd16));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_MANUAL, 16'd10000, 32'd20));
    pending_req.push_back(healthy_req(REQ_STEP, CMD_STOP, 16'd0, 32'd60));
    // gap of exactly twice the period holds, one more ms trips timing
    pending_req.push_back(healthy_req(REQ_STEP, CMD_STOP, 16'd0, 32'd160));
    pending_req.push_back(healthy_req(REQ_STEP, CMD_STOP, 16'd0, 32'd261));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_STOP, 16'd0, 32'd262));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_MANUAL, 16'd500, 32'd263));
    r = healthy_req(REQ_COMMAND, CMD_RESET, 16'd0, 32'd264);
    r.ready_req = 1'b0;
    pending_req.push_back(r);
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_RESET, 16'd0, 32'd265));
    // sample stamped in the future reads as stale
    r = healthy_req(REQ_COMMAND, CMD_MANUAL, 16'd1, 32'd266);
    r.sample_time_ms = 32'd267;
    pending_req.push_back(r);
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_RESET, 16'd0, 32'd270));
    r = healthy_req(REQ_COMMAND, CMD_MANUAL, 16'd300, 32'd271);
    r.door_shut = 1'b0;
    pending_req.push_back(r);
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_RESET, 16'd0, 32'd272));
    r = healthy_req(REQ_COMMAND, CMD_MANUAL, 16'd300, 32'd273);
    r.ready_req     = 1'b0;
    r.stop_chain_ok = 1'b0;
    pending_req.push_back(r);
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_RESET, 16'd0, 32'd275));
    r = healthy_req(REQ_COMMAND, CMD_MANUAL, 16'd200, 32'd280);
    r.air_before = 16'sh7FFF;
    pending_req.push_back(r);
    // reset refused while manual, then the command timeout trips
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_RESET, 16'd0, 32'd281));
    pending_req.push_back(healthy_req(REQ_STEP, CMD_STOP, 16'd0, 32'd1280));
    // time wraps; negative airspeed trips the sensor fault
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_RESET, 16'd0, 32'hFFFF_FFF0));
    pending_req.push_back(healthy_req(REQ_COMMAND, CMD_MANUAL, 16'd100, 32'hFFFF_FFF8));
    r = healthy_req(REQ_STEP, CMD_STOP, 16'd0, 32'd8);
    r.sample_time_ms = 32'hFFFF_FFFF;
    r.air_after      = 16'sh8000;
    pending_req.push_back(r);
    drain();

    // Random phases over low, high, zero, default and random configurations
    run_phase(0, 16'd0, 16'd1, 16'd1, 16'd0);
    run_phase(1, 16'hFFFF, 16'hFFFF, 16'd32767, 16'd10000);
    run_phase(2, 16'd100, 16'd0, 16'd0, 16'd5000);
    run_phase(3, SensorMaxAgeRst, CmdTimeoutRst, 16'(StepPeriodRst), 16'(MaxLevelRst));
    for (int p = 4; p < 8; p++) begin
      run_phase(p, 16'($urandom_range(0, 500)), 16'($urandom_range(1, 3000)),
                16'($urandom_range(1, 200)), 16'($urandom_range(1, 10000)));
    end

    if (mismatches == 0 && status_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dsi_pkg.sv
rtl/dsi_cfg_regs.sv
rtl/dsi_health.sv
rtl/dsi_ctrl.sv
rtl/drive_safety_interlock.sv
dv/drive_safety_interlock_tb.sv
